// ===== src/cose_pkg.sv =====
`timescale 1ns / 1ps

package cose_pkg;

	// operation classes produced by the front decoder
	localparam logic [3:0] OP_NONE   = 4'd0;
	localparam logic [3:0] OP_LD_BC  = 4'd1;
	localparam logic [3:0] OP_INC_BC = 4'd2;
	localparam logic [3:0] OP_INC_B  = 4'd3;
	localparam logic [3:0] OP_DEC_B  = 4'd4;
	localparam logic [3:0] OP_LD_B   = 4'd5;
	localparam logic [3:0] OP_RLCA   = 4'd6;
	localparam logic [3:0] OP_ADD_HL = 4'd7;
	localparam logic [3:0] OP_DEC_BC = 4'd8;
	localparam logic [3:0] OP_INC_C  = 4'd9;
	localparam logic [3:0] OP_DEC_C  = 4'd10;

	// opcode bytes of the supported subset
	localparam logic [7:0] OPC_NOP    = 8'h00;
	localparam logic [7:0] OPC_LD_BC  = 8'h01;
	localparam logic [7:0] OPC_INC_BC = 8'h03;
	localparam logic [7:0] OPC_INC_B  = 8'h04;
	localparam logic [7:0] OPC_DEC_B  = 8'h05;
	localparam logic [7:0] OPC_LD_B   = 8'h06;
	localparam logic [7:0] OPC_RLCA   = 8'h07;
	localparam logic [7:0] OPC_ADD_HL = 8'h09;
	localparam logic [7:0] OPC_DEC_BC = 8'h0B;
	localparam logic [7:0] OPC_INC_C  = 8'h0C;
	localparam logic [7:0] OPC_DEC_C  = 8'h0D;

	// register values after reset
	localparam logic [7:0]  RST_ACC   = 8'h01;
	localparam logic [3:0]  RST_FLAGS = 4'hB;
	localparam logic [7:0]  RST_B     = 8'h00;
	localparam logic [7:0]  RST_C     = 8'h13;
	localparam logic [7:0]  RST_H     = 8'h01;
	localparam logic [7:0]  RST_L     = 8'h4D;
	localparam logic [15:0] RST_PC    = 16'h0100;

	// bit positions inside the upper flag nibble
	localparam int FLAG_Z = 3;
	localparam int FLAG_N = 2;
	localparam int FLAG_H = 1;
	localparam int FLAG_C = 0;

	// queue depth between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// one decoded request
	typedef struct packed {
		logic [3:0] op;
		logic [1:0] pc_inc;
		logic       unsup;
		logic [7:0] imm_lo;
		logic [7:0] imm_hi;
	} dec_item_t;

	// queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

// ===== src/cpu_opcode_subset_execute.sv =====
// an accepted request is written into the queue, then executed into the result registers once the result slot is free
// throughput: one request per cycle while the receiver keeps out_ready high
// a two-entry queue between decode and execute absorbs output stalls
// reset: asynchronous, active low; registers return to their power-on values,
// program counter to 0x0100, queue and result slot empty
`timescale 1ns / 1ps

module cpu_opcode_subset_execute (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  opcode,
	input  logic [7:0]  imm_lo,
	input  logic [7:0]  imm_hi,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] pc_out,
	output logic [7:0]  acc_out,
	output logic [7:0]  flags_out,
	output logic [7:0]  reg_b_out,
	output logic [7:0]  reg_c_out,
	output logic [7:0]  reg_h_out,
	output logic [7:0]  reg_l_out,
	output logic        unsupported
);
	import cose_pkg::*;

	q_status_t q_status;
	dec_item_t push_item;
	dec_item_t head_item;
	logic      push;
	logic      pop;

	// front: accept and classify
	cose_decode u_decode (
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.imm_lo    (imm_lo),
		.imm_hi    (imm_hi),
		.q_status  (q_status),
		.push      (push),
		.push_item (push_item)
	);

	// decoupling queue
	cose_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head_item (head_item),
		.q_status  (q_status)
	);

	// back: execute and hold the result
	cose_execute u_execute (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_status    (q_status),
		.head_item   (head_item),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pc_out      (pc_out),
		.acc_out     (acc_out),
		.flags_out   (flags_out),
		.reg_b_out   (reg_b_out),
		.reg_c_out   (reg_c_out),
		.reg_h_out   (reg_h_out),
		.reg_l_out   (reg_l_out),
		.unsupported (unsupported)
	);

endmodule

// ===== src/cose_decode.sv =====
`timescale 1ns / 1ps

module cose_decode (
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          opcode,
	input  logic [7:0]          imm_lo,
	input  logic [7:0]          imm_hi,
	input  cose_pkg::q_status_t q_status,
	output logic                push,
	output cose_pkg::dec_item_t push_item
);
	import cose_pkg::*;

	// take a request whenever the queue has room
	assign in_ready = !q_status.full;
	assign push     = in_valid && !q_status.full;

	// classify the opcode and fix the instruction length
	always_comb begin
		push_item.imm_lo = imm_lo;
		push_item.imm_hi = imm_hi;
		push_item.pc_inc = 2'd1;
		push_item.unsup  = 1'b0;
		push_item.op     = OP_NONE;
		case (opcode)
			OPC_NOP: begin
				push_item.op = OP_NONE;
			end
			OPC_LD_BC: begin
				push_item.op     = OP_LD_BC;
				push_item.pc_inc = 2'd3;
			end
			OPC_INC_BC: push_item.op = OP_INC_BC;
			OPC_INC_B:  push_item.op = OP_INC_B;
			OPC_DEC_B:  push_item.op = OP_DEC_B;
			OPC_LD_B: begin
				push_item.op     = OP_LD_B;
				push_item.pc_inc = 2'd2;
			end
			OPC_RLCA:   push_item.op = OP_RLCA;
			OPC_ADD_HL: push_item.op = OP_ADD_HL;
			OPC_DEC_BC: push_item.op = OP_DEC_BC;
			OPC_INC_C:  push_item.op = OP_INC_C;
			OPC_DEC_C:  push_item.op = OP_DEC_C;
			default: begin
				push_item.op    = OP_NONE;
				push_item.unsup = 1'b1;
			end
		endcase
	end

endmodule

// ===== src/cose_queue.sv =====
`timescale 1ns / 1ps

module cose_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  cose_pkg::dec_item_t push_item,
	input  logic                pop,
	output cose_pkg::dec_item_t head_item,
	output cose_pkg::q_status_t q_status
);
	import cose_pkg::*;

	dec_item_t          mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;

	assign q_status.full  = (count_q == QCNT_W'(QDEPTH));
	assign q_status.empty = (count_q == '0);
	assign head_item      = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== src/cose_execute.sv =====
`timescale 1ns / 1ps

module cose_execute (
	input  logic                clk,
	input  logic                arst_n,
	input  cose_pkg::q_status_t q_status,
	input  cose_pkg::dec_item_t head_item,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [15:0]         pc_out,
	output logic [7:0]          acc_out,
	output logic [7:0]          flags_out,
	output logic [7:0]          reg_b_out,
	output logic [7:0]          reg_c_out,
	output logic [7:0]          reg_h_out,
	output logic [7:0]          reg_l_out,
	output logic                unsupported
);
	import cose_pkg::*;

	// architectural state, which is also the visible result
	logic [7:0]  acc_q;
	logic [3:0]  flags_q;
	logic [7:0]  b_q;
	logic [7:0]  c_q;
	logic [7:0]  h_q;
	logic [7:0]  l_q;
	logic [15:0] pc_q;
	logic        unsup_q;
	logic        out_valid_q;

	logic [7:0]  acc_d;
	logic [3:0]  flags_d;
	logic [7:0]  b_d;
	logic [7:0]  c_d;
	logic [7:0]  h_d;
	logic [7:0]  l_d;
	logic [15:0] bc_step;
	logic [16:0] hl_sum;
	logic [12:0] half_sum;
	logic [7:0]  r8;

	// execute the head request once the result slot is free or draining
	assign pop = !q_status.empty && (!out_valid_q || out_ready);

	// 16-bit datapath for pair ops
	assign bc_step  = (head_item.op == OP_DEC_BC) ? ({b_q, c_q} - 16'd1) : ({b_q, c_q} + 16'd1);
	assign hl_sum   = {1'b0, h_q, l_q} + {1'b0, b_q, c_q};
	assign half_sum = {1'b0, h_q[3:0], l_q} + {1'b0, b_q[3:0], c_q};

	// next state per operation class
	always_comb begin
		acc_d   = acc_q;
		flags_d = flags_q;
		b_d     = b_q;
		c_d     = c_q;
		h_d     = h_q;
		l_d     = l_q;
		r8      = '0;
		case (head_item.op)
			OP_LD_BC: begin
				c_d = head_item.imm_lo;
				b_d = head_item.imm_hi;
			end
			OP_INC_BC, OP_DEC_BC: begin
				b_d = bc_step[15:8];
				c_d = bc_step[7:0];
			end
			OP_INC_B: begin
				r8             = b_q + 8'd1;
				b_d            = r8;
				flags_d[FLAG_H] = (b_q[3:0] == 4'hF);
				flags_d[FLAG_N] = 1'b0;
				flags_d[FLAG_Z] = (r8 == 8'd0);
			end
			OP_DEC_B: begin
				r8             = b_q - 8'd1;
				b_d            = r8;
				flags_d[FLAG_H] = (b_q[3:0] == 4'h0);
				flags_d[FLAG_N] = 1'b1;
				flags_d[FLAG_Z] = (r8 == 8'd0);
			end
			OP_INC_C: begin
				r8             = c_q + 8'd1;
				c_d            = r8;
				flags_d[FLAG_H] = (c_q[3:0] == 4'hF);
				flags_d[FLAG_N] = 1'b0;
				flags_d[FLAG_Z] = (r8 == 8'd0);
			end
			OP_DEC_C: begin
				r8             = c_q - 8'd1;
				c_d            = r8;
				flags_d[FLAG_H] = (c_q[3:0] == 4'h0);
				flags_d[FLAG_N] = 1'b1;
				flags_d[FLAG_Z] = (r8 == 8'd0);
			end
			OP_LD_B: begin
				b_d = head_item.imm_lo;
			end
			OP_RLCA: begin
				acc_d   = {acc_q[6:0], acc_q[7]};
				flags_d = {3'b000, acc_q[7]};
			end
			OP_ADD_HL: begin
				h_d             = hl_sum[15:8];
				l_d             = hl_sum[7:0];
				flags_d[FLAG_H] = half_sum[12];
				flags_d[FLAG_C] = hl_sum[16];
				flags_d[FLAG_N] = 1'b0;
			end
			default: begin
				acc_d = acc_q;
			end
		endcase
	end

	// state and result slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= RST_ACC;
			flags_q     <= RST_FLAGS;
			b_q         <= RST_B;
			c_q         <= RST_C;
			h_q         <= RST_H;
			l_q         <= RST_L;
			pc_q        <= RST_PC;
			unsup_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				acc_q       <= acc_d;
				flags_q     <= flags_d;
				b_q         <= b_d;
				c_q         <= c_d;
				h_q         <= h_d;
				l_q         <= l_d;
				pc_q        <= pc_q + {14'd0, head_item.pc_inc};
				unsup_q     <= head_item.unsup;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign pc_out      = pc_q;
	assign acc_out     = acc_q;
	assign flags_out   = {flags_q, 4'h0};
	assign reg_b_out   = b_q;
	assign reg_c_out   = c_q;
	assign reg_h_out   = h_q;
	assign reg_l_out   = l_q;
	assign unsupported = unsup_q;

endmodule

// ===== sim/cpu_state_checker.sv =====
`timescale 1ns / 1ps

module cpu_state_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  opcode,
	input  logic [7:0]  imm_lo,
	input  logic [7:0]  imm_hi,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [15:0] pc_out,
	input  logic [7:0]  acc_out,
	input  logic [7:0]  flags_out,
	input  logic [7:0]  reg_b_out,
	input  logic [7:0]  reg_c_out,
	input  logic [7:0]  reg_h_out,
	input  logic [7:0]  reg_l_out,
	input  logic        unsupported,
	output int          errors,
	output int          pending
);
	import cose_pkg::*;

	// flag bit positions inside the full flags byte
	localparam int BIT_Z = FLAG_Z + 4;
	localparam int BIT_N = FLAG_N + 4;
	localparam int BIT_H = FLAG_H + 4;
	localparam int BIT_C = FLAG_C + 4;

	// architectural view reported after each instruction
	typedef struct packed {
		logic [15:0] pc;
		logic [7:0]  a;
		logic [7:0]  f;
		logic [7:0]  b;
		logic [7:0]  c;
		logic [7:0]  h;
		logic [7:0]  l;
		logic        unsup;
	} cpu_view_t;

	cpu_view_t cpu_now;
	cpu_view_t reg_file_q[$];
	int        err_cnt;

	// execute one instruction on a copy of the register file
	function automatic cpu_view_t execute_opcode(cpu_view_t s, logic [7:0] op,
			logic [7:0] lo, logic [7:0] hi);
		cpu_view_t   n;
		logic [15:0] bc;
		logic [16:0] sum;
		logic [12:0] half;
		logic [1:0]  len;
		n = s;
		n.unsup = 1'b0;
		len = 2'd1;
		bc = {s.b, s.c};
		case (op)
			OPC_NOP: begin
			end
			OPC_LD_BC: begin
				n.c = lo;
				n.b = hi;
				len = 2'd3;
			end
			OPC_INC_BC: {n.b, n.c} = bc + 16'd1;
			OPC_DEC_BC: {n.b, n.c} = bc - 16'd1;
			OPC_INC_B: begin
				n.b = s.b + 8'd1;
				n.f[BIT_H] = (s.b[3:0] == 4'hF);
				n.f[BIT_N] = 1'b0;
				n.f[BIT_Z] = (n.b == 8'd0);
			end
			OPC_DEC_B: begin
				n.b = s.b - 8'd1;
				n.f[BIT_H] = (s.b[3:0] == 4'h0);
				n.f[BIT_N] = 1'b1;
				n.f[BIT_Z] = (n.b == 8'd0);
			end
			OPC_INC_C: begin
				n.c = s.c + 8'd1;
				n.f[BIT_H] = (s.c[3:0] == 4'hF);
				n.f[BIT_N] = 1'b0;
				n.f[BIT_Z] = (n.c == 8'd0);
			end
			OPC_DEC_C: begin
				n.c = s.c - 8'd1;
				n.f[BIT_H] = (s.c[3:0] == 4'h0);
				n.f[BIT_N] = 1'b1;
				n.f[BIT_Z] = (n.c == 8'd0);
			end
			OPC_LD_B: begin
				n.b = lo;
				len = 2'd2;
			end
			OPC_RLCA: begin
				n.a = {s.a[6:0], s.a[7]};
				n.f = 8'h00;
				n.f[BIT_C] = s.a[7];
			end
			OPC_ADD_HL: begin
				sum = {1'b0, s.h, s.l} + {1'b0, bc};
				half = {1'b0, s.h[3:0], s.l} + {1'b0, bc[11:0]};
				n.f[BIT_H] = half[12];
				n.f[BIT_C] = sum[16];
				n.f[BIT_N] = 1'b0;
				{n.h, n.l} = sum[15:0];
			end
			default: n.unsup = 1'b1;
		endcase
		n.f[3:0] = 4'h0;
		n.pc = s.pc + 16'(len);
		return n;
	endfunction

	// report one field that differs
	task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %h got %h", $time, name, want, got);
			err_cnt++;
		end
	endtask

	// predict on each accepted request, compare on each accepted result
	always @(posedge clk or negedge arst_n) begin
		cpu_view_t want;
		if (!arst_n) begin
			cpu_now = '{pc: RST_PC, a: RST_ACC, f: {RST_FLAGS, 4'h0}, b: RST_B,
				c: RST_C, h: RST_H, l: RST_L, unsup: 1'b0};
			reg_file_q.delete();
			err_cnt = 0;
		end else begin
			if (in_valid && in_ready) begin
				cpu_now = execute_opcode(cpu_now, opcode, imm_lo, imm_hi);
				reg_file_q = {reg_file_q, cpu_now};
			end
			if (out_valid && out_ready) begin
				if (reg_file_q.size() == 0) begin
					$display("%0t: result with nothing expected, pc %h", $time, pc_out);
					err_cnt++;
				end else begin
					want = reg_file_q.pop_front();
					check_field("pc_out", want.pc, pc_out);
					check_field("acc_out", 16'(want.a), 16'(acc_out));
					check_field("flags_out", 16'(want.f), 16'(flags_out));
					check_field("reg_b_out", 16'(want.b), 16'(reg_b_out));
					check_field("reg_c_out", 16'(want.c), 16'(reg_c_out));
					check_field("reg_h_out", 16'(want.h), 16'(reg_h_out));
					check_field("reg_l_out", 16'(want.l), 16'(reg_l_out));
					check_field("unsupported", 16'(want.unsup), 16'(unsupported));
				end
			end
		end
		errors <= err_cnt;
		pending <= reg_file_q.size();
	end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import cose_pkg::*;

	localparam int ITEMS_PER_PHASE = 325;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  opcode;
	logic [7:0]  imm_lo;
	logic [7:0]  imm_hi;
	logic        out_valid;
	logic        out_ready;
	logic [15:0] pc_out;
	logic [7:0]  acc_out;
	logic [7:0]  flags_out;
	logic [7:0]  reg_b_out;
	logic [7:0]  reg_c_out;
	logic [7:0]  reg_h_out;
	logic [7:0]  reg_l_out;
	logic        unsupported;
	int          errors;
	int          pending;
	int          sender_idle_pct;
	int          stall_pct;

	// supported opcodes, weighted heavily in the random part
	logic [7:0] known_ops [11] = '{OPC_NOP, OPC_LD_BC, OPC_INC_BC, OPC_INC_B, OPC_DEC_B,
		OPC_LD_B, OPC_RLCA, OPC_ADD_HL, OPC_DEC_BC, OPC_INC_C, OPC_DEC_C};

	cpu_opcode_subset_execute uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .imm_lo(imm_lo), .imm_hi(imm_hi),
		.out_valid(out_valid), .out_ready(out_ready),
		.pc_out(pc_out), .acc_out(acc_out), .flags_out(flags_out),
		.reg_b_out(reg_b_out), .reg_c_out(reg_c_out),
		.reg_h_out(reg_h_out), .reg_l_out(reg_l_out),
		.unsupported(unsupported)
	);

	cpu_state_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .imm_lo(imm_lo), .imm_hi(imm_hi),
		.out_valid(out_valid), .out_ready(out_ready),
		.pc_out(pc_out), .acc_out(acc_out), .flags_out(flags_out),
		.reg_b_out(reg_b_out), .reg_c_out(reg_c_out),
		.reg_h_out(reg_h_out), .reg_l_out(reg_l_out),
		.unsupported(unsupported),
		.errors(errors), .pending(pending)
	);

	// 8 ns clock
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// receiver stalls at the current rate
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// hard stop
	initial begin
		#5_000_000;
		$display("testbench: errors");
		$finish;
	end

	// present one instruction request and hold it until accepted
	task automatic send_instr(logic [7:0] op, logic [7:0] lo, logic [7:0] hi);
		logic took;
		if ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < sender_idle_pct) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		imm_lo <= lo;
		imm_hi <= hi;
		do begin
			@(negedge clk);
			took = in_ready;
			@(posedge clk);
		end while (!took);
	endtask

	// drop valid and hold off until every result is back
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	// random byte that often lands on an extreme
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(9))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	initial begin
		logic [7:0] op;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		opcode <= 8'h00;
		imm_lo <= 8'h00;
		imm_hi <= 8'h00;
		sender_idle_pct = 0;
		stall_pct = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: wraps, flag corners, rotate carry, unfinished and unknown codes
		send_instr(OPC_NOP, 8'hFF, 8'hFF);
		send_instr(OPC_LD_BC, 8'hFF, 8'hFF);
		send_instr(OPC_INC_BC, 8'h00, 8'h00);
		send_instr(OPC_DEC_BC, 8'hFF, 8'h00);
		send_instr(OPC_ADD_HL, 8'h5A, 8'hA5);
		send_instr(OPC_LD_BC, 8'h0F, 8'h00);
		send_instr(OPC_DEC_B, 8'h00, 8'hFF);
		send_instr(OPC_INC_B, 8'hFF, 8'h00);
		send_instr(OPC_INC_C, 8'h00, 8'h00);
		send_instr(OPC_DEC_C, 8'h00, 8'h00);
		send_instr(OPC_LD_B, 8'h01, 8'hFF);
		send_instr(OPC_DEC_B, 8'h00, 8'h00);
		repeat (8) send_instr(OPC_RLCA, 8'hA5, 8'h5A);
		send_instr(8'h02, 8'hA5, 8'h5A);
		send_instr(8'h08, 8'h5A, 8'hA5);
		send_instr(8'h0A, 8'hFF, 8'hFF);
		send_instr(8'h0E, 8'h00, 8'h00);
		send_instr(8'hFF, 8'hFF, 8'hFF);
		drain_results();

		// random phases: no idling, sender idle, receiver stall, both light
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin sender_idle_pct = 0; stall_pct = 0; end
				1: begin sender_idle_pct = 70; stall_pct = 0; end
				2: begin sender_idle_pct = 0; stall_pct = 70; end
				default: begin sender_idle_pct = 14; stall_pct = 14; end
			endcase
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				if ($urandom_range(99) < 80)
					op = known_ops[$urandom_range(10)];
				else
					op = 8'($urandom_range(255));
				send_instr(op, pick_byte(), pick_byte());
			end
			drain_results();
		end

		// settle and give the verdict
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
